[src/bcc_pkg.sv]
// ----------------------------------------------------------------------------
// Button click classifier package
// Field widths, command codes and register indexes shared by the channel
// interfaces and the classifier core.
// ----------------------------------------------------------------------------
package bcc_pkg;

   localparam int unsigned BUTTON_W = 5;
   localparam int unsigned COUNT_W  = 16;
   localparam int unsigned CSR_IDX_W  = 1;
   localparam int unsigned CSR_DATA_W = 16;

   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_TICK   = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_DOUBLE_WINDOW = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_TIME     = 1'b1;

   localparam logic [COUNT_W-1:0] DOUBLE_WINDOW_RESET = 16'd50;
   localparam logic [COUNT_W-1:0] LONG_TIME_RESET     = 16'd100;

endpackage

[src/bcc_channels.sv]
// ----------------------------------------------------------------------------
// Button click classifier channels
// Valid/ready interfaces for the request items and the result items.
// ----------------------------------------------------------------------------
interface bcc_req_if;
   logic                          valid;
   logic                          ready;
   logic                          command;
   logic [bcc_pkg::BUTTON_W-1:0]  button;
   logic                          level;

   modport source (output valid, output command, output button, output level,
                   input ready);
   modport sink (input valid, input command, input button, input level,
                 output ready);
endinterface

interface bcc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bcc_pkg::BUTTON_W-1:0]  which_button;
   logic                          press_event;
   logic                          double_event;
   logic                          release_event;
   logic                          final_release_event;
   logic                          single_done_event;
   logic                          long_event;

   modport source (output valid, output which_button, output press_event,
                   output double_event, output release_event,
                   output final_release_event, output single_done_event,
                   output long_event, input ready);
   modport sink (input valid, input which_button, input press_event,
                 input double_event, input release_event,
                 input final_release_event, input single_done_event,
                 input long_event, output ready);
endinterface

[src/button_click_classifier_core.sv]
// ----------------------------------------------------------------------------
// Button click classifier core
// An accepted request item goes through the input register, then the result
// register. Throughput: one item per cycle while results are taken; the
// per-button state is read and rewritten in the cycle an item leaves the
// input register. Synchronous active-high reset clears all button state and
// loads the default window and long-press times; no clearing pass is needed.
// ----------------------------------------------------------------------------
module button_click_classifier_core #(
   parameter int unsigned BUTTON_COUNT = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   bcc_req_if.sink                              req_chan,
   bcc_rsp_if.source                            rsp_chan,
   input  logic                                 csr_write_en,
   input  logic [bcc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [bcc_pkg::CSR_DATA_W-1:0]       csr_write_data
);

   // Only buttons that the 5-bit index can reach need state.
   localparam int unsigned MAX_BUTTONS = 1 << bcc_pkg::BUTTON_W;
   localparam int unsigned DEPTH = (BUTTON_COUNT < MAX_BUTTONS) ? BUTTON_COUNT
                                                                 : MAX_BUTTONS;
   localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   typedef struct packed {
      logic                          held;
      logic                          single_pending;
      logic                          release_pending;
      logic [bcc_pkg::COUNT_W-1:0]   double_count;
      logic [bcc_pkg::COUNT_W-1:0]   long_count;
   } btn_state_type;

   logic [bcc_pkg::COUNT_W-1:0] double_window_ff;
   logic [bcc_pkg::COUNT_W-1:0] long_time_ff;

   btn_state_type state_ff [DEPTH];

   logic                          s1_valid_ff;
   logic                          s1_command_ff;
   logic [bcc_pkg::BUTTON_W-1:0]  s1_button_ff;
   logic                          s1_level_ff;

   logic                          out_valid_ff;
   logic [bcc_pkg::BUTTON_W-1:0]  out_button_ff;
   logic                          out_press_ff;
   logic                          out_double_ff;
   logic                          out_release_ff;
   logic                          out_final_ff;
   logic                          out_single_ff;
   logic                          out_long_ff;

   logic          out_free;
   logic          s1_advance;
   logic          req_take;
   logic          in_range;
   logic [IDX_W-1:0] idx;
   btn_state_type cur;
   btn_state_type state_in;
   logic          press_in;
   logic          double_in;
   logic          release_in;
   logic          final_in;
   logic          single_in;
   logic          long_in;

   assign out_free   = !out_valid_ff || rsp_chan.ready;
   assign s1_advance = s1_valid_ff && out_free;
   assign req_chan.ready = !s1_valid_ff || out_free;
   assign req_take   = req_chan.valid && req_chan.ready;

   assign in_range = {4'b0, s1_button_ff} < 9'(BUTTON_COUNT);
   assign idx      = s1_button_ff[IDX_W-1:0];
   assign cur      = state_ff[idx];

   always_comb begin
      state_in   = cur;
      press_in   = 1'b0;
      double_in  = 1'b0;
      release_in = 1'b0;
      final_in   = 1'b0;
      single_in  = 1'b0;
      long_in    = 1'b0;
      if (in_range) begin
         case (s1_command_ff)
            bcc_pkg::CMD_SAMPLE: begin
               if (s1_level_ff && !cur.held) begin
                  state_in.held       = 1'b1;
                  state_in.long_count = long_time_ff;
                  press_in            = 1'b1;
                  if (cur.double_count != '0) begin
                     double_in                = 1'b1;
                     state_in.double_count    = '0;
                     state_in.single_pending  = 1'b0;
                     state_in.release_pending = 1'b0;
                  end else begin
                     state_in.double_count   = double_window_ff;
                     state_in.single_pending = 1'b1;
                  end
               end else if (!s1_level_ff && cur.held) begin
                  state_in.held = 1'b0;
                  release_in    = 1'b1;
                  if (cur.double_count == '0) begin
                     final_in = 1'b1;
                  end else begin
                     state_in.release_pending = 1'b1;
                  end
               end
            end
            bcc_pkg::CMD_TICK: begin
               if (cur.long_count != '0) begin
                  state_in.long_count = cur.long_count - 1'b1;
                  long_in = (cur.long_count == bcc_pkg::COUNT_W'(1)) && cur.held;
               end
               if (cur.double_count != '0) begin
                  state_in.double_count = cur.double_count - 1'b1;
                  // The window closes on this tick: settle what was waiting on it.
                  if (cur.double_count == bcc_pkg::COUNT_W'(1)) begin
                     single_in                = cur.single_pending;
                     final_in                 = cur.release_pending;
                     state_in.single_pending  = 1'b0;
                     state_in.release_pending = 1'b0;
                  end
               end
            end
            default: begin
               state_in = cur;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         double_window_ff <= bcc_pkg::DOUBLE_WINDOW_RESET;
         long_time_ff     <= bcc_pkg::LONG_TIME_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            bcc_pkg::CSR_DOUBLE_WINDOW: double_window_ff <= csr_write_data;
            bcc_pkg::CSR_LONG_TIME:     long_time_ff     <= csr_write_data;
            default: begin
               double_window_ff <= double_window_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            state_ff[i] <= '0;
         end
      end else if (s1_advance && in_range) begin
         state_ff[idx] <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_command_ff <= req_chan.command;
         s1_button_ff  <= req_chan.button;
         s1_level_ff   <= req_chan.level;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         out_button_ff  <= s1_button_ff;
         out_press_ff   <= press_in;
         out_double_ff  <= double_in;
         out_release_ff <= release_in;
         out_final_ff   <= final_in;
         out_single_ff  <= single_in;
         out_long_ff    <= long_in;
      end
   end

   assign rsp_chan.valid               = out_valid_ff;
   assign rsp_chan.which_button        = out_button_ff;
   assign rsp_chan.press_event         = out_press_ff;
   assign rsp_chan.double_event        = out_double_ff;
   assign rsp_chan.release_event       = out_release_ff;
   assign rsp_chan.final_release_event = out_final_ff;
   assign rsp_chan.single_done_event   = out_single_ff;
   assign rsp_chan.long_event          = out_long_ff;

endmodule
